// ===== rtl/core/psh_pkg.sv =====
// Shared types, constants and lookup tables for the pixel shuffle scatter block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package psh_pkg;

  // Shape limits
  localparam int MAX_BATCH    = 256;
  localparam int MAX_SCALE    = 8;
  localparam int MAX_CHANNELS = 4096;
  localparam int MAX_SIDE     = 2048;

  // Field and counter widths
  localparam int ELEM_W  = 32;
  localparam int IDX_W   = 42;
  localparam int BATCH_W = $clog2(MAX_BATCH);
  localparam int CHAN_W  = 12;
  localparam int ROW_W   = 14;
  localparam int COL_W   = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SCALE_W    = 4;
  localparam int DEEP_W     = 13;
  localparam int SIDE_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_CH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd4;

  localparam logic DIR_FORWARD = 1'b0;

  // Reciprocal divider: quotient estimate is (x * floor(2^14 / d)) >> 14
  localparam int DIV_X_W     = 14;
  localparam int DIV_D_W     = 8;
  localparam int DIV_M_W     = 15;
  localparam int RECIP_SHIFT = 14;

  // floor(2^14 / r) for r = 0..15 (zero entry unused)
  localparam logic [DIV_M_W-1:0] RECIP_R [16] = '{
    15'd0,    15'd16384, 15'd8192, 15'd5461, 15'd4096, 15'd3276, 15'd2730, 15'd2340,
    15'd2048, 15'd1820,  15'd1638, 15'd1489, 15'd1365, 15'd1260, 15'd1170, 15'd1092
  };

  // floor(2^14 / r^2) for r = 0..15 (zero entry unused)
  localparam logic [DIV_M_W-1:0] RECIP_RR [16] = '{
    15'd0,   15'd16384, 15'd4096, 15'd1820, 15'd1024, 15'd655, 15'd455, 15'd334,
    15'd256, 15'd202,   15'd163,  15'd135,  15'd113,  15'd96,  15'd83,  15'd72
  };

  // Index multiply-accumulate widths
  localparam int MUL_X_W = 36;
  localparam int MUL_Y_W = 16;
  localparam int ADD_W   = 20;

  // Channel payloads
  typedef struct packed {
    logic [ELEM_W-1:0] element_value;
    logic              first_element;
  } psh_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  dest_index;
    logic [ELEM_W-1:0] element_out;
    logic              shape_error;
  } psh_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV0,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_DIV4,
    ST_DIV5,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_DONE
  } psh_state_t;

  // Divide operations (operand and destination select)
  typedef enum logic [2:0] {
    DV_NONE,
    DV_TC,
    DV_C_RR,
    DV_C_R,
    DV_Q_R,
    DV_H_R,
    DV_W_R
  } psh_div_op_t;

  // Index accumulation steps
  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_S0,
    MAC_S1,
    MAC_S2,
    MAC_S3
  } psh_mac_t;

  typedef struct packed {
    logic        load;
    psh_div_op_t div_op;
    psh_mac_t    mac;
    logic        finish;
  } psh_cmd_t;

  typedef struct packed {
    logic dir;
    logic out_busy;
  } psh_stat_t;

  typedef struct packed {
    logic               valid;
    psh_div_op_t        op;
    logic [DIV_X_W-1:0] x;
    logic [DIV_D_W-1:0] d;
    logic [DIV_M_W-1:0] m;
  } psh_div_req_t;

  typedef struct packed {
    logic               valid;
    psh_div_op_t        op;
    logic [DIV_X_W-1:0] q;
    logic [DIV_D_W-1:0] rem;
  } psh_div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pixel_shuffle_scatter.sv =====
// Pixel shuffle scatter: pairs each element with its depth-to-space destination index.
// The result register loads as the sequencer leaves its done state, which waits while the output stalls.
// A new element is taken only once the sequencer is idle again, after walking one shared
// reciprocal divider and one index MAC through its steps.
// Reset (rst_n low, synchronous): counters cleared, config to r=2, C=4, H=1, W=1, forward.
// Depends on psh_pkg, psh_ctrl, psh_dpath and psh_div.
`default_nettype none

module pixel_shuffle_scatter (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  psh_pkg::psh_in_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output psh_pkg::psh_out_t                 out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [psh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [psh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  psh_pkg::psh_cmd_t  cmd;
  psh_pkg::psh_stat_t stat;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  psh_ctrl u_psh_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  psh_dpath u_psh_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/psh_div.sv =====
// Two-stage reciprocal divider for small divisors (r or r squared).
// Depends on psh_pkg for request/result types and table widths.
`default_nettype none

module psh_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  psh_pkg::psh_div_req_t req,
  output psh_pkg::psh_div_res_t res
);

  logic                          valid_r;
  psh_pkg::psh_div_op_t          op_r;
  logic [psh_pkg::DIV_X_W-1:0]   x_r;
  logic [psh_pkg::DIV_D_W-1:0]   d_r;
  logic [psh_pkg::DIV_X_W-1:0]   q0_r;

  logic [psh_pkg::DIV_X_W+psh_pkg::DIV_M_W-1:0] est;
  logic [psh_pkg::DIV_X_W+psh_pkg::DIV_D_W-1:0] qd;
  logic [psh_pkg::DIV_X_W-1:0]                  rem0;
  logic [psh_pkg::DIV_X_W-1:0]                  d_ext;

  // Estimate quotient: exact or one short
  assign est = (psh_pkg::DIV_X_W+psh_pkg::DIV_M_W)'(req.x)
             * (psh_pkg::DIV_X_W+psh_pkg::DIV_M_W)'(req.m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= req.op;
    x_r  <= req.x;
    d_r  <= req.d;
    q0_r <= est[psh_pkg::RECIP_SHIFT +: psh_pkg::DIV_X_W];
  end

  // Correct the estimate with one compare and subtract
  assign qd    = (psh_pkg::DIV_X_W+psh_pkg::DIV_D_W)'(q0_r)
               * (psh_pkg::DIV_X_W+psh_pkg::DIV_D_W)'(d_r);
  assign rem0  = x_r - qd[psh_pkg::DIV_X_W-1:0];
  assign d_ext = psh_pkg::DIV_X_W'(d_r);

  always_comb begin
    res.valid = valid_r;
    res.op    = op_r;
    if (rem0 >= d_ext) begin
      res.q   = q0_r + psh_pkg::DIV_X_W'(1);
      res.rem = psh_pkg::DIV_D_W'(rem0 - d_ext);
    end else begin
      res.q   = q0_r;
      res.rem = psh_pkg::DIV_D_W'(rem0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psh_ctrl.sv =====
// Sequencer for one element: divides, index accumulation, result hand-off.
// Depends on psh_pkg for the state, command and status types.
`default_nettype none

module psh_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  psh_pkg::psh_stat_t  stat,
  output psh_pkg::psh_cmd_t   cmd
);

  psh_pkg::psh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: wait in idle for an element, walk the steps, hold at the end until output frees
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psh_pkg::ST_IDLE: if (in_valid) state_nxt = psh_pkg::ST_DIV0;
      psh_pkg::ST_DIV0: state_nxt = psh_pkg::ST_DIV1;
      psh_pkg::ST_DIV1: state_nxt = psh_pkg::ST_DIV2;
      psh_pkg::ST_DIV2: state_nxt = psh_pkg::ST_DIV3;
      psh_pkg::ST_DIV3: state_nxt = psh_pkg::ST_DIV4;
      psh_pkg::ST_DIV4: state_nxt = psh_pkg::ST_DIV5;
      psh_pkg::ST_DIV5: state_nxt = psh_pkg::ST_MAC0;
      psh_pkg::ST_MAC0: state_nxt = psh_pkg::ST_MAC1;
      psh_pkg::ST_MAC1: state_nxt = psh_pkg::ST_MAC2;
      psh_pkg::ST_MAC2: state_nxt = psh_pkg::ST_MAC3;
      psh_pkg::ST_MAC3: state_nxt = psh_pkg::ST_DONE;
      psh_pkg::ST_DONE: if (!stat.out_busy) state_nxt = psh_pkg::ST_IDLE;
      default:          state_nxt = psh_pkg::ST_IDLE;
    endcase
  end

  // Outputs: at most one command per step
  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.div_op = psh_pkg::DV_NONE;
    cmd.mac    = psh_pkg::MAC_NONE;
    cmd.finish = 1'b0;
    case (state_r)
      psh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      psh_pkg::ST_DIV0: cmd.div_op = psh_pkg::DV_TC;
      psh_pkg::ST_DIV1: cmd.div_op = stat.dir ? psh_pkg::DV_H_R : psh_pkg::DV_C_RR;
      psh_pkg::ST_DIV2: cmd.div_op = stat.dir ? psh_pkg::DV_W_R : psh_pkg::DV_C_R;
      psh_pkg::ST_DIV4: cmd.div_op = stat.dir ? psh_pkg::DV_NONE : psh_pkg::DV_Q_R;
      psh_pkg::ST_MAC0: cmd.mac = psh_pkg::MAC_S0;
      psh_pkg::ST_MAC1: cmd.mac = psh_pkg::MAC_S1;
      psh_pkg::ST_MAC2: cmd.mac = psh_pkg::MAC_S2;
      psh_pkg::ST_MAC3: cmd.mac = psh_pkg::MAC_S3;
      psh_pkg::ST_DONE: cmd.finish = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/psh_dpath.sv =====
// Datapath: config registers, position counters, divider, index MAC, output register.
// Depends on psh_pkg and instantiates psh_div.
`default_nettype none

module psh_dpath (
  input  wire                               clk,
  input  wire                               rst_n,
  input  psh_pkg::psh_in_t                  in_data,
  input  psh_pkg::psh_cmd_t                 cmd,
  output psh_pkg::psh_stat_t                stat,
  input  wire                               cfg_valid,
  input  wire [psh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [psh_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output psh_pkg::psh_out_t                 out_data
);

  // Configuration
  logic [psh_pkg::SCALE_W-1:0] scale_r;
  logic [psh_pkg::DEEP_W-1:0]  deep_r;
  logic [psh_pkg::SIDE_W-1:0]  low_h_r;
  logic [psh_pkg::SIDE_W-1:0]  low_w_r;
  logic                        dir_r;

  // Derived shape values
  logic [psh_pkg::DIV_D_W-1:0] rr_r;
  logic [psh_pkg::MUL_Y_W-1:0] th_r;
  logic [psh_pkg::MUL_Y_W-1:0] tw_r;
  logic                        bad_cfg_r;

  // Position counters
  logic [psh_pkg::BATCH_W-1:0] batch_r, batch_nxt;
  logic [psh_pkg::CHAN_W-1:0]  chan_r, chan_nxt;
  logic [psh_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [psh_pkg::COL_W-1:0]   col_r, col_nxt;

  // Per-element work registers
  logic [psh_pkg::ELEM_W-1:0]  elem_r;
  logic [psh_pkg::DEEP_W-1:0]  tc_r;
  logic                        mod_bad_r;
  logic [psh_pkg::CHAN_W-1:0]  nc_r;
  logic [psh_pkg::CHAN_W-1:0]  q2_r;
  logic [psh_pkg::SCALE_W-1:0] lo_r;
  logic [psh_pkg::SCALE_W-1:0] mid_r;
  logic [psh_pkg::SCALE_W-1:0] hrem_r;
  logic [psh_pkg::SCALE_W-1:0] wrem_r;
  logic [psh_pkg::ROW_W-1:0]   oh_r;
  logic [psh_pkg::COL_W-1:0]   ow_r;
  logic [psh_pkg::ROW_W+psh_pkg::SCALE_W-1:0] nh_r;
  logic [psh_pkg::COL_W+psh_pkg::SCALE_W-1:0] nw_r;
  logic [psh_pkg::DIV_D_W-1:0] oca_r;
  logic [psh_pkg::IDX_W-1:0]   acc_r, acc_nxt;

  logic                        out_valid_r;
  psh_pkg::psh_out_t           out_data_r;

  psh_pkg::psh_div_req_t       div_req;
  psh_pkg::psh_div_res_t       div_res;

  logic [psh_pkg::MUL_X_W-1:0] mul_x;
  logic [psh_pkg::MUL_Y_W-1:0] mul_y;
  logic [psh_pkg::ADD_W-1:0]   add_z;
  logic [psh_pkg::MUL_X_W+psh_pkg::MUL_Y_W-1:0] mul_p;

  logic [psh_pkg::MUL_Y_W-1:0] lim_c, lim_h, lim_w;
  logic [psh_pkg::COL_W:0]     col_inc;
  logic [psh_pkg::ROW_W:0]     row_inc;
  logic [psh_pkg::CHAN_W:0]    chan_inc;
  logic                        shape_err;
  logic                        out_load;

  // Config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= psh_pkg::SCALE_W'(2);
      deep_r  <= psh_pkg::DEEP_W'(4);
      low_h_r <= psh_pkg::SIDE_W'(1);
      low_w_r <= psh_pkg::SIDE_W'(1);
      dir_r   <= psh_pkg::DIR_FORWARD;
    end else if (cfg_valid) begin
      case (cfg_index)
        psh_pkg::CFG_SCALE:     scale_r <= cfg_data[psh_pkg::SCALE_W-1:0];
        psh_pkg::CFG_DEEP_CH:   deep_r  <= cfg_data[psh_pkg::DEEP_W-1:0];
        psh_pkg::CFG_LOW_H:     low_h_r <= cfg_data[psh_pkg::SIDE_W-1:0];
        psh_pkg::CFG_LOW_W:     low_w_r <= cfg_data[psh_pkg::SIDE_W-1:0];
        psh_pkg::CFG_DIRECTION: dir_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Track shape products and range checks behind the config registers
  always_ff @(posedge clk) begin
    rr_r <= psh_pkg::DIV_D_W'(scale_r) * psh_pkg::DIV_D_W'(scale_r);
    th_r <= psh_pkg::MUL_Y_W'(low_h_r) * psh_pkg::MUL_Y_W'(scale_r);
    tw_r <= psh_pkg::MUL_Y_W'(low_w_r) * psh_pkg::MUL_Y_W'(scale_r);
    bad_cfg_r <= (scale_r == '0) || (scale_r > psh_pkg::MAX_SCALE)
              || (deep_r == '0)  || (deep_r > psh_pkg::MAX_CHANNELS)
              || (low_h_r == '0) || (low_h_r > psh_pkg::MAX_SIDE)
              || (low_w_r == '0) || (low_w_r > psh_pkg::MAX_SIDE);
  end

  // Divider operand select
  always_comb begin
    div_req.valid = (cmd.div_op != psh_pkg::DV_NONE);
    div_req.op    = cmd.div_op;
    div_req.x     = '0;
    div_req.d     = psh_pkg::DIV_D_W'(scale_r);
    div_req.m     = psh_pkg::RECIP_R[scale_r];
    case (cmd.div_op)
      psh_pkg::DV_TC: begin
        div_req.x = psh_pkg::DIV_X_W'(deep_r);
        div_req.d = rr_r;
        div_req.m = psh_pkg::RECIP_RR[scale_r];
      end
      psh_pkg::DV_C_RR: begin
        div_req.x = psh_pkg::DIV_X_W'(chan_r);
        div_req.d = rr_r;
        div_req.m = psh_pkg::RECIP_RR[scale_r];
      end
      psh_pkg::DV_C_R: div_req.x = psh_pkg::DIV_X_W'(chan_r);
      psh_pkg::DV_Q_R: div_req.x = psh_pkg::DIV_X_W'(q2_r);
      psh_pkg::DV_H_R: div_req.x = psh_pkg::DIV_X_W'(row_r);
      psh_pkg::DV_W_R: div_req.x = psh_pkg::DIV_X_W'(col_r);
      default: ;
    endcase
  end

  psh_div u_psh_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Capture divider results by operation tag
  always_ff @(posedge clk) begin
    if (div_res.valid) begin
      case (div_res.op)
        psh_pkg::DV_TC: begin
          tc_r      <= div_res.q[psh_pkg::DEEP_W-1:0];
          mod_bad_r <= (div_res.rem != '0);
        end
        psh_pkg::DV_C_RR: nc_r <= div_res.q[psh_pkg::CHAN_W-1:0];
        psh_pkg::DV_C_R: begin
          q2_r <= div_res.q[psh_pkg::CHAN_W-1:0];
          lo_r <= div_res.rem[psh_pkg::SCALE_W-1:0];
        end
        psh_pkg::DV_Q_R: mid_r <= div_res.rem[psh_pkg::SCALE_W-1:0];
        psh_pkg::DV_H_R: begin
          oh_r   <= div_res.q[psh_pkg::ROW_W-1:0];
          hrem_r <= div_res.rem[psh_pkg::SCALE_W-1:0];
        end
        psh_pkg::DV_W_R: begin
          ow_r   <= div_res.q[psh_pkg::COL_W-1:0];
          wrem_r <= div_res.rem[psh_pkg::SCALE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Build the addends for row, column and channel from the divide results
  always_ff @(posedge clk) begin
    nh_r  <= (psh_pkg::ROW_W+psh_pkg::SCALE_W)'(row_r)
           * (psh_pkg::ROW_W+psh_pkg::SCALE_W)'(scale_r)
           + (psh_pkg::ROW_W+psh_pkg::SCALE_W)'(mid_r);
    nw_r  <= (psh_pkg::COL_W+psh_pkg::SCALE_W)'(col_r)
           * (psh_pkg::COL_W+psh_pkg::SCALE_W)'(scale_r)
           + (psh_pkg::COL_W+psh_pkg::SCALE_W)'(lo_r);
    oca_r <= psh_pkg::DIV_D_W'(hrem_r) * psh_pkg::DIV_D_W'(scale_r)
           + psh_pkg::DIV_D_W'(wrem_r);
  end

  // Index MAC: acc = x * y + z, four steps per element
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    add_z = '0;
    case (cmd.mac)
      psh_pkg::MAC_S0: begin
        mul_x = dir_r ? psh_pkg::MUL_X_W'(chan_r) : '0;
        mul_y = psh_pkg::MUL_Y_W'(rr_r);
        add_z = dir_r ? psh_pkg::ADD_W'(oca_r) : psh_pkg::ADD_W'(batch_r);
      end
      psh_pkg::MAC_S1: begin
        mul_x = dir_r ? psh_pkg::MUL_X_W'(batch_r) : acc_r[psh_pkg::MUL_X_W-1:0];
        mul_y = dir_r ? psh_pkg::MUL_Y_W'(deep_r) : psh_pkg::MUL_Y_W'(tc_r);
        add_z = dir_r ? acc_r[psh_pkg::ADD_W-1:0] : psh_pkg::ADD_W'(nc_r);
      end
      psh_pkg::MAC_S2: begin
        mul_x = acc_r[psh_pkg::MUL_X_W-1:0];
        mul_y = dir_r ? psh_pkg::MUL_Y_W'(low_h_r) : th_r;
        add_z = dir_r ? psh_pkg::ADD_W'(oh_r) : psh_pkg::ADD_W'(nh_r);
      end
      psh_pkg::MAC_S3: begin
        mul_x = acc_r[psh_pkg::MUL_X_W-1:0];
        mul_y = dir_r ? psh_pkg::MUL_Y_W'(low_w_r) : tw_r;
        add_z = dir_r ? psh_pkg::ADD_W'(ow_r) : psh_pkg::ADD_W'(nw_r);
      end
      default: ;
    endcase
  end

  assign mul_p   = (psh_pkg::MUL_X_W+psh_pkg::MUL_Y_W)'(mul_x)
                 * (psh_pkg::MUL_X_W+psh_pkg::MUL_Y_W)'(mul_y);
  assign acc_nxt = mul_p[psh_pkg::IDX_W-1:0] + psh_pkg::IDX_W'(add_z);

  always_ff @(posedge clk) begin
    if (cmd.mac != psh_pkg::MAC_NONE) begin
      acc_r <= acc_nxt;
    end
  end

  // Advance source position: column, then row, then channel, then batch
  always_comb begin
    lim_w    = dir_r ? tw_r : psh_pkg::MUL_Y_W'(low_w_r);
    lim_h    = dir_r ? th_r : psh_pkg::MUL_Y_W'(low_h_r);
    lim_c    = dir_r ? psh_pkg::MUL_Y_W'(tc_r) : psh_pkg::MUL_Y_W'(deep_r);
    col_inc  = (psh_pkg::COL_W+1)'(col_r) + (psh_pkg::COL_W+1)'(1);
    row_inc  = (psh_pkg::ROW_W+1)'(row_r) + (psh_pkg::ROW_W+1)'(1);
    chan_inc = (psh_pkg::CHAN_W+1)'(chan_r) + (psh_pkg::CHAN_W+1)'(1);
    batch_nxt = batch_r;
    chan_nxt  = chan_r;
    row_nxt   = row_r;
    col_nxt   = col_inc[psh_pkg::COL_W-1:0];
    if (psh_pkg::MUL_Y_W'(col_inc) >= lim_w) begin
      col_nxt = '0;
      row_nxt = row_inc[psh_pkg::ROW_W-1:0];
      if (psh_pkg::MUL_Y_W'(row_inc) >= lim_h) begin
        row_nxt  = '0;
        chan_nxt = chan_inc[psh_pkg::CHAN_W-1:0];
        if (psh_pkg::MUL_Y_W'(chan_inc) >= lim_c) begin
          chan_nxt = '0;
          if (batch_r == psh_pkg::BATCH_W'(psh_pkg::MAX_BATCH - 1)) begin
            batch_nxt = '0;
          end else begin
            batch_nxt = batch_r + psh_pkg::BATCH_W'(1);
          end
        end
      end
    end
  end

  assign shape_err = bad_cfg_r || mod_bad_r;

  // Counters: clear on first element or shape error, advance on finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= '0;
      chan_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else if ((cmd.load && in_data.first_element) || (cmd.finish && shape_err)) begin
      batch_r <= '0;
      chan_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else if (cmd.finish) begin
      batch_r <= batch_nxt;
      chan_r  <= chan_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // Hold the element bits for the duration of the work
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem_r <= in_data.element_value;
    end
  end

  // Output register: load on finish, drop valid after the transfer
  assign out_load = cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.dest_index  <= shape_err ? '0 : acc_r;
      out_data_r.element_out <= elem_r;
      out_data_r.shape_error <= shape_err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.dir      = dir_r;
  assign stat.out_busy = out_valid_r && out_stall;

endmodule

`default_nettype wire

// ===== rtl/core/psh_checker.sv =====
// Port-level checks for pixel_shuffle_scatter, attached by bind.
// Depends on psh_pkg for the payload types.
`default_nettype none

module psh_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input wire                            out_stall,
  input psh_pkg::psh_out_t              out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // A shape error always carries a zero index
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shape_error |-> out_data.dest_index == '0)
    else $error("shape error with nonzero index");

  // The block is busy right after taking an element
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second element taken without a busy cycle");

endmodule

bind pixel_shuffle_scatter psh_checker u_psh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/pixel_shuffle_scatter_test.sv =====
// Self-checking testbench for pixel_shuffle_scatter: streams elements under many shapes and
// checks every destination index, element and shape flag against an in-bench index tracker.
// Depends on psh_pkg and the pixel_shuffle_scatter RTL only.
`timescale 1ns / 1ps

module pixel_shuffle_scatter_test;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int PRESSURE_AT   = 100;
  localparam int PRESSURE_HOLD = 300;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic DIR_BACKWARD = ~psh_pkg::DIR_FORWARD;

  // Tracks source position and shape, predicts where each element lands
  class scatter_tracker;
    bit [psh_pkg::SCALE_W-1:0] scale;
    bit [psh_pkg::DEEP_W-1:0]  chans;
    bit [psh_pkg::SIDE_W-1:0]  rows;
    bit [psh_pkg::SIDE_W-1:0]  cols;
    bit                        dir;
    bit [psh_pkg::BATCH_W-1:0] batch;
    bit [psh_pkg::CHAN_W-1:0]  chan;
    bit [psh_pkg::ROW_W-1:0]   row;
    bit [psh_pkg::COL_W-1:0]   col;
    psh_pkg::psh_out_t         pending[$];
    int unsigned               mismatches;
    int unsigned               checked;
    int unsigned               flagged;

    function new();
      scale = 2;
      chans = 4;
      rows = 1;
      cols = 1;
      dir = psh_pkg::DIR_FORWARD;
      restart();
      mismatches = 0;
      checked = 0;
      flagged = 0;
    endfunction

    function void restart();
      batch = '0;
      chan = '0;
      row = '0;
      col = '0;
    endfunction

    function void set_reg(logic [psh_pkg::CFG_IDX_W-1:0] idx,
                          logic [psh_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        psh_pkg::CFG_SCALE:     scale = data[psh_pkg::SCALE_W-1:0];
        psh_pkg::CFG_DEEP_CH:   chans = data[psh_pkg::DEEP_W-1:0];
        psh_pkg::CFG_LOW_H:     rows = data[psh_pkg::SIDE_W-1:0];
        psh_pkg::CFG_LOW_W:     cols = data[psh_pkg::SIDE_W-1:0];
        psh_pkg::CFG_DIRECTION: dir = data[0];
        default: ;
      endcase
    endfunction

    // Compute the destination of one element and advance the source position
    function psh_pkg::psh_out_t place(psh_pkg::psh_in_t e);
      longint unsigned r, rr, bc, bh, bw, tc, th, tw;
      longint unsigned n, c, h, w, sc, sh, sw, idx;
      bit bad;
      psh_pkg::psh_out_t res;
      if (e.first_element) restart();
      res.element_out = e.element_value;
      res.dest_index = '0;
      res.shape_error = 1'b1;
      r = scale;
      bc = chans;
      bh = rows;
      bw = cols;
      bad = r == 0 || r > psh_pkg::MAX_SCALE || bc == 0 || bc > psh_pkg::MAX_CHANNELS ||
            bh == 0 || bh > psh_pkg::MAX_SIDE || bw == 0 || bw > psh_pkg::MAX_SIDE;
      if (!bad) bad = (bc % (r * r)) != 0;
      if (bad) begin
        restart();
        flagged++;
        return res;
      end
      rr = r * r;
      tc = bc / rr;
      th = bh * r;
      tw = bw * r;
      n = batch;
      c = chan;
      h = row;
      w = col;
      if (dir == psh_pkg::DIR_FORWARD) begin
        idx = ((n * tc + c / rr) * th + h * r + (c / r) % r) * tw + w * r + c % r;
        sc = bc;
        sh = bh;
        sw = bw;
      end else begin
        idx = ((n * bc + c * rr + (h % r) * r + w % r) * bh + h / r) * bw + w / r;
        sc = tc;
        sh = th;
        sw = tw;
      end
      // Advance column, carry into row, channel and batch
      w = w + 1;
      if (w >= sw) begin
        w = 0;
        h = h + 1;
        if (h >= sh) begin
          h = 0;
          c = c + 1;
          if (c >= sc) begin
            c = 0;
            n = (n + 1) % psh_pkg::MAX_BATCH;
          end
        end
      end
      batch = n[psh_pkg::BATCH_W-1:0];
      chan = c[psh_pkg::CHAN_W-1:0];
      row = h[psh_pkg::ROW_W-1:0];
      col = w[psh_pkg::COL_W-1:0];
      res.dest_index = idx[psh_pkg::IDX_W-1:0];
      res.shape_error = 1'b0;
      return res;
    endfunction

    function void note_element(psh_pkg::psh_in_t e);
      pending = {pending, place(e)};
    endfunction

    function void check_result(psh_pkg::psh_out_t got);
      psh_pkg::psh_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: idx %0h elem %0h err %0b",
                   $time, got.dest_index, got.element_out, got.shape_error);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.dest_index !== want.dest_index || got.element_out !== want.element_out ||
          got.shape_error !== want.shape_error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result %0d expected idx %0h elem %0h err %0b, got idx %0h elem %0h err %0b",
                   $time, checked, want.dest_index, want.element_out, want.shape_error,
                   got.dest_index, got.element_out, got.shape_error);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  psh_pkg::psh_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  psh_pkg::psh_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [psh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned    cycle_count = 0;
  int unsigned    items_sent = 0;
  int unsigned    shapes_used = 0;
  bit             send_calm = 1'b0;
  scatter_tracker track = new();

  pixel_shuffle_scatter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Offer one element after a random gap; hold it until the transfer
  task automatic send_element(input logic [psh_pkg::ELEM_W-1:0] value, input logic first);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{element_value: value, first_element: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track.note_element(in_data);
    items_sent++;
  endtask

  // Drop valid and wait for every pending result
  task automatic quiesce();
    in_valid <= 1'b0;
    while (track.pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register, sometimes with junk above its width; valid stays high
  task automatic write_reg(input logic [psh_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    int unsigned width;
    logic [psh_pkg::CFG_DATA_W-1:0] data;
    case (idx)
      psh_pkg::CFG_SCALE:                    width = psh_pkg::SCALE_W;
      psh_pkg::CFG_LOW_H, psh_pkg::CFG_LOW_W: width = psh_pkg::SIDE_W;
      psh_pkg::CFG_DIRECTION:                width = 1;
      default:                               width = psh_pkg::CFG_DATA_W;
    endcase
    data = value[psh_pkg::CFG_DATA_W-1:0];
    if (width < psh_pkg::CFG_DATA_W && $urandom_range(0, 3) == 0)
      data = data | (psh_pkg::CFG_DATA_W'($urandom) << width);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track.set_reg(idx, data);
  endtask

  // Reprogram the whole shape once the block has drained
  task automatic set_shape(input int unsigned r, c, h, w, input logic dir);
    quiesce();
    write_reg(psh_pkg::CFG_SCALE, r);
    write_reg(psh_pkg::CFG_DEEP_CH, c);
    write_reg(psh_pkg::CFG_LOW_H, h);
    write_reg(psh_pkg::CFG_LOW_W, w);
    write_reg(psh_pkg::CFG_DIRECTION, 32'(dir));
    // Unmapped indexes must be ignored
    if ($urandom_range(0, 3) == 0)
      write_reg(psh_pkg::CFG_IDX_W'(psh_pkg::CFG_DIRECTION + 1 + $urandom_range(0, 2)),
                $urandom_range(0, 8191));
    cfg_valid <= 1'b0;
    shapes_used++;
  endtask

  task automatic run_phase(input int unsigned count, input bit restart, input bit stray);
    logic [psh_pkg::ELEM_W-1:0] value;
    logic first;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      first = (i == 0 && restart) || (stray && $urandom_range(0, 39) == 0);
      send_element(value, first);
    end
  endtask

  // Mostly small legal shapes, some up to full size, a fifth illegal
  task automatic random_phase();
    int unsigned r, rr, c, h, w, kind;
    bit big;
    logic dir;
    dir = $urandom_range(0, 1) ? DIR_BACKWARD : psh_pkg::DIR_FORWARD;
    kind = $urandom_range(0, 9);
    big = kind == 6 || kind == 7;
    r = big ? $urandom_range(1, psh_pkg::MAX_SCALE) : $urandom_range(1, 4);
    rr = r * r;
    if (big) begin
      c = rr * $urandom_range(1, psh_pkg::MAX_CHANNELS / rr);
      h = $urandom_range(1, psh_pkg::MAX_SIDE);
      w = $urandom_range(1, psh_pkg::MAX_SIDE);
    end else begin
      c = rr * $urandom_range(1, 3);
      h = $urandom_range(1, 4);
      w = $urandom_range(1, 4);
    end
    if (kind >= 8) begin
      case ($urandom_range(0, 4))
        0: r = $urandom_range(0, 1) ? 0 : $urandom_range(psh_pkg::MAX_SCALE + 1, 15);
        1: c = $urandom_range(0, 1) ? 0 : $urandom_range(psh_pkg::MAX_CHANNELS + 1, 8191);
        2: h = $urandom_range(0, 1) ? 0 : $urandom_range(psh_pkg::MAX_SIDE + 1, 4095);
        3: w = $urandom_range(0, 1) ? 0 : $urandom_range(psh_pkg::MAX_SIDE + 1, 4095);
        default: begin
          r = $urandom_range(2, psh_pkg::MAX_SCALE);
          rr = r * r;
          c = rr * $urandom_range(0, psh_pkg::MAX_CHANNELS / rr - 1)
            + $urandom_range(1, rr - 1);
        end
      endcase
    end
    set_shape(r, c, h, w, dir);
    run_phase(kind >= 8 ? $urandom_range(2, 8) : $urandom_range(20, 100),
              $urandom_range(0, 3) != 0, 1'b1);
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : result_side
    int unsigned hold;
    bit calm;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (track.checked == PRESSURE_AT) hold = PRESSURE_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      track.check_result(out_data);
    end
  end

  initial begin : watchdog
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, track.pending.size());
    $display("FAIL pixel_shuffle_scatter");
    $finish;
  end

  initial begin : stimulus
    int unsigned start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset shape: element extremes and a full tensor plus wrap into the next batch
    send_element('0, 1'b1);
    send_element('1, 1'b0);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b0);
    send_element($urandom, 1'b0);

    // Largest legal shapes in both directions
    set_shape(1, psh_pkg::MAX_CHANNELS, psh_pkg::MAX_SIDE, psh_pkg::MAX_SIDE,
              psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b1);
    send_element($urandom, 1'b0);
    set_shape(psh_pkg::MAX_SCALE, psh_pkg::MAX_CHANNELS, psh_pkg::MAX_SIDE,
              psh_pkg::MAX_SIDE, DIR_BACKWARD);
    send_element($urandom, 1'b1);
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b0);

    // Space to depth over a whole small tensor
    set_shape(2, 4, 1, 1, DIR_BACKWARD);
    send_element($urandom, 1'b1);
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b0);

    // Illegal shapes: channels not a multiple of r squared, then each field out of range
    set_shape(3, 4, 1, 1, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b0);
    set_shape(0, 4, 1, 1, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b0);
    set_shape(15, 4, 1, 1, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b1);
    set_shape(2, 0, 1, 1, DIR_BACKWARD);
    send_element($urandom, 1'b0);
    set_shape(2, 8191, 1, 1, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b0);
    set_shape(2, 4, 0, 1, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b1);
    set_shape(2, 4, 4095, 1, DIR_BACKWARD);
    send_element($urandom, 1'b0);
    set_shape(2, 4, 1, 0, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b0);
    set_shape(2, 4, 1, 4095, psh_pkg::DIR_FORWARD);
    send_element($urandom, 1'b0);

    start = items_sent;

    // One element per batch: run the batch counter up to its last value
    set_shape(1, 1, 1, 1, psh_pkg::DIR_FORWARD);
    run_phase(psh_pkg::MAX_BATCH - 1, 1'b1, 1'b0);
    // Advance the channel counter past what the next shape allows
    set_shape(1, psh_pkg::MAX_CHANNELS, 1, 1, psh_pkg::DIR_FORWARD);
    run_phase(70, 1'b0, 1'b0);
    // Stale channel plus top batch overflows the 42-bit index
    set_shape(psh_pkg::MAX_SCALE, psh_pkg::MAX_CHANNELS, psh_pkg::MAX_SIDE,
              psh_pkg::MAX_SIDE, DIR_BACKWARD);
    run_phase(8, 1'b0, 1'b0);

    while (items_sent - start < RANDOM_ITEMS) random_phase();

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d elements checked over %0d shapes, %0d with a bad-shape flag",
             track.checked, shapes_used, track.flagged);
    $display("%0d mismatches, %0d cycles", track.mismatches, cycle_count);
    if (track.mismatches == 0 && track.pending.size() == 0) begin
      $display("PASS pixel_shuffle_scatter");
    end else begin
      $display("FAIL pixel_shuffle_scatter");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/psh_pkg.sv
rtl/core/psh_div.sv
rtl/core/psh_ctrl.sv
rtl/core/psh_dpath.sv
rtl/core/pixel_shuffle_scatter.sv
rtl/core/psh_checker.sv
tb/pixel_shuffle_scatter_test.sv
